// ----- src/rgd_pkg.sv -----
// ----------------------------------------------------------------------------
// rgd_pkg: shared types and constants for the raster grid decimator
// Grid size, source size limits, counter widths and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rgd_pkg;

  // Output grid and source limits
  localparam int unsigned OUT_ROWS = 15;
  localparam int unsigned OUT_COLS = 15;
  localparam int unsigned MAX_DIM  = 1024;

  // Field widths
  localparam int unsigned DIM_W   = 11;  // size registers
  localparam int unsigned VAL_W   = 8;   // cell value
  localparam int unsigned COORD_W = 4;   // out_row / out_col

  // Counter widths
  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned GR_W  = $clog2(OUT_ROWS + 1);
  localparam int unsigned GC_W  = $clog2(OUT_COLS + 1);

  // Product widths for the threshold compares
  localparam int unsigned RP_W = DIM_W + GR_W;
  localparam int unsigned CP_W = DIM_W + GC_W + 1;

  // Result queue
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = Q_AW + 1;

  // Register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_SRC_ROWS = 1'b0;
  localparam logic REG_SRC_COLS = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } rgd_result_t;

  // Up to two results per source cell
  typedef struct packed {
    logic        vld0;
    logic        vld1;
    rgd_result_t r0;
    rgd_result_t r1;
  } rgd_push_t;

  // Zero acts as one, oversize acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/raster_grid_decimator_top.sv -----
// ----------------------------------------------------------------------------
// raster_grid_decimator_top: nearest-neighbor downscale onto a 15x15 grid
// Source cells in raster order in, selected grid cells with coordinates out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one source cell (pixel_i) per valid/ready transaction, in
//   raster order, row by row. Output channel: one grid write per transaction
//   (out_value_o, out_row_o, out_col_o, last_o). The last cell of each frame
//   also produces a corner write (14,14) with last_o set, after any ordinary
//   write of that cell. Unwritten grid cells are zero at the consumer.
//   Sizes are set over the APB port: src_rows at 0x0, src_cols at 0x4.
//   An accepted cell waits in the input register until the queue has room;
//   its result is then registered in the queue and presented from there.
//   Throughput: one cell per cycle unless stalled; the two-result cell
//   at frame end is absorbed by the 4-entry result queue, which also sets how
//   far the block runs ahead of a stalled receiver. Frames of one or two
//   cells emit more writes than cells and pace the input to the output rate.
//   Stall: when the receiver holds off, the queue fills and in_ready_o drops
//   once fewer than two entries are free; nothing is lost.
//   Reset: counters and queue clear, both size registers return to 15.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_grid_decimator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rgd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [rgd_pkg::APB_DW-1:0]    pwdata,
  output logic      [rgd_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  // Source cell stream
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rgd_pkg::VAL_W-1:0]     pixel_i,
  // Grid write stream
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rgd_pkg::VAL_W-1:0]     out_value_o,
  output logic      [rgd_pkg::COORD_W-1:0]   out_row_o,
  output logic      [rgd_pkg::COORD_W-1:0]   out_col_o,
  output logic                               last_o
);

  // Configuration registers
  logic [rgd_pkg::DIM_W-1:0] src_rows_q, src_cols_q;
  logic                      cfg_wr;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rows_q <= rgd_pkg::DIM_W'(15);
      src_cols_q <= rgd_pkg::DIM_W'(15);
    end else if (cfg_wr) begin
      case (reg_sel)
        rgd_pkg::REG_SRC_ROWS: src_rows_q <= pwdata[rgd_pkg::DIM_W-1:0];
        rgd_pkg::REG_SRC_COLS: src_cols_q <= pwdata[rgd_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rgd_pkg::REG_SRC_ROWS: prdata = rgd_pkg::APB_DW'(src_rows_q);
      rgd_pkg::REG_SRC_COLS: prdata = rgd_pkg::APB_DW'(src_cols_q);
      default:               prdata = '0;
    endcase
  end

  // Input register: holds one accepted cell until the core steps on it
  logic                      ivld_q, ivld_d;
  logic [rgd_pkg::VAL_W-1:0] pix_q;
  logic                      room, fire, in_acc;

  assign fire       = ivld_q && room;
  assign in_ready_o = !ivld_q || room;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    if (in_acc) begin
      ivld_d = 1'b1;
    end else if (fire) begin
      ivld_d = 1'b0;
    end else begin
      ivld_d = ivld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivld_q <= 1'b0;
    end else begin
      ivld_q <= ivld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q <= pixel_i;
    end
  end

  // Selection core
  rgd_pkg::rgd_push_t   push;
  rgd_pkg::rgd_result_t head;

  rgd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (fire),
    .pixel_i (pix_q),
    .rows_i  (rgd_pkg::clamp_dim(src_rows_q)),
    .cols_i  (rgd_pkg::clamp_dim(src_cols_q)),
    .push_o  (push)
  );

  // Result queue, output side
  rgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .head_o  (head),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i)
  );

  assign out_value_o = head.value;
  assign out_row_o   = head.row;
  assign out_col_o   = head.col;
  assign last_o      = head.last;

`ifndef NO_ASSERTIONS
  // The frame-end write always targets the corner cell
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |->
      out_row_o == rgd_pkg::COORD_W'(rgd_pkg::OUT_ROWS - 1) &&
      out_col_o == rgd_pkg::COORD_W'(rgd_pkg::OUT_COLS - 1))
    else $error("last write not at grid corner");

  // Input stalls only with a cell held in the input register
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ivld_q)
    else $error("input stalled with empty input register");

  // A second result per cell is always the frame-end corner write
  a_second_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld1 |-> push.vld0 && push.r1.last && !push.r0.last)
    else $error("bad second result");

  // The core never steps without a held cell
  a_step_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld0 |-> ivld_q && room)
    else $error("result without source cell");
`endif

endmodule

`default_nettype wire

// ----- src/rgd_core.sv -----
// ----------------------------------------------------------------------------
// rgd_core: raster position counters and cell selection
// Tracks the source position and grid progress, emits up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module rgd_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [rgd_pkg::VAL_W-1:0]  pixel_i,
  input  wire logic [rgd_pkg::DIM_W-1:0]  rows_i,
  input  wire logic [rgd_pkg::DIM_W-1:0]  cols_i,
  output rgd_pkg::rgd_push_t              push_o
);

  logic [rgd_pkg::CNT_W-1:0] row_cnt_q, row_cnt_d;
  logic [rgd_pkg::CNT_W-1:0] col_cnt_q, col_cnt_d;
  logic [rgd_pkg::GR_W-1:0]  grid_row_q, grid_row_d;
  logic [rgd_pkg::GC_W-1:0]  grid_col_q, grid_col_d;
  logic                      row_taken_q, row_taken_d;

  logic [rgd_pkg::RP_W-1:0] row_prod, row_lim;
  logic [rgd_pkg::CP_W-1:0] col_prod, col_lim;
  logic row_ok, taken, cell_take, row_end, frame_end;
  rgd_pkg::rgd_result_t cell_res, corner_res;

  // floor(a/N) <= c  <=>  a < N*(c+1): no divider needed
  always_comb begin
    row_prod = rgd_pkg::RP_W'(rows_i) * rgd_pkg::RP_W'(grid_row_q);
    row_lim  = rgd_pkg::RP_W'(rgd_pkg::OUT_ROWS) * (rgd_pkg::RP_W'(row_cnt_q) + 1'b1);
    col_prod = rgd_pkg::CP_W'(cols_i) * (rgd_pkg::CP_W'(grid_col_q) + 1'b1);
    col_lim  = rgd_pkg::CP_W'(rgd_pkg::OUT_COLS) * (rgd_pkg::CP_W'(col_cnt_q) + 1'b1);

    row_ok    = (grid_row_q < rgd_pkg::GR_W'(rgd_pkg::OUT_ROWS)) && (row_prod < row_lim);
    taken     = (col_cnt_q == '0) ? row_ok : row_taken_q;
    cell_take = taken && (grid_col_q < rgd_pkg::GC_W'(rgd_pkg::OUT_COLS))
                && (col_prod < col_lim);
    row_end   = rgd_pkg::DIM_W'(col_cnt_q) >= (cols_i - 1'b1);
    frame_end = row_end && (rgd_pkg::DIM_W'(row_cnt_q) >= (rows_i - 1'b1));
  end

  always_comb begin
    grid_col_d  = row_end ? '0 : grid_col_q + rgd_pkg::GC_W'(cell_take);
    col_cnt_d   = row_end ? '0 : col_cnt_q + 1'b1;
    row_taken_d = frame_end ? 1'b0 : taken;
    if (frame_end) begin
      grid_row_d = '0;
      row_cnt_d  = '0;
    end else begin
      grid_row_d = grid_row_q + rgd_pkg::GR_W'(row_end && taken);
      row_cnt_d  = row_cnt_q + rgd_pkg::CNT_W'(row_end);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
      grid_row_q  <= '0;
      grid_col_q  <= '0;
      row_taken_q <= 1'b0;
    end else if (step_i) begin
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
      grid_row_q  <= grid_row_d;
      grid_col_q  <= grid_col_d;
      row_taken_q <= row_taken_d;
    end
  end

  always_comb begin
    cell_res.value   = pixel_i;
    cell_res.row     = rgd_pkg::COORD_W'(grid_row_q);
    cell_res.col     = rgd_pkg::COORD_W'(grid_col_q);
    cell_res.last    = 1'b0;
    corner_res.value = pixel_i;
    corner_res.row   = rgd_pkg::COORD_W'(rgd_pkg::OUT_ROWS - 1);
    corner_res.col   = rgd_pkg::COORD_W'(rgd_pkg::OUT_COLS - 1);
    corner_res.last  = 1'b1;

    // Ordinary write goes first, corner write after it
    push_o.vld0 = step_i && (cell_take || frame_end);
    push_o.vld1 = step_i && cell_take && frame_end;
    push_o.r0   = cell_take ? cell_res : corner_res;
    push_o.r1   = corner_res;
  end

endmodule

`default_nettype wire

// ----- src/rgd_fifo.sv -----
// ----------------------------------------------------------------------------
// rgd_fifo: small result queue
// Takes up to two results per cycle, hands out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rgd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rgd_pkg::rgd_push_t push_i,
  output logic                 room_o,
  output rgd_pkg::rgd_result_t head_o,
  output logic                 valid_o,
  input  wire logic            ready_i
);

  rgd_pkg::rgd_result_t mem_q [rgd_pkg::Q_DEPTH];
  logic [rgd_pkg::Q_AW-1:0] wr_q, wr_d, rd_q, rd_d, wr_second;
  logic [rgd_pkg::Q_CW-1:0] cnt_q, cnt_d;
  logic pop;

  assign pop       = valid_o && ready_i;
  assign valid_o   = cnt_q != '0;
  assign head_o    = mem_q[rd_q];
  assign room_o    = cnt_q <= rgd_pkg::Q_CW'(rgd_pkg::Q_DEPTH - 2);
  assign wr_second = wr_q + rgd_pkg::Q_AW'(push_i.vld0);

  always_comb begin
    wr_d  = wr_q + rgd_pkg::Q_AW'(push_i.vld0) + rgd_pkg::Q_AW'(push_i.vld1);
    rd_d  = rd_q + rgd_pkg::Q_AW'(pop);
    cnt_d = cnt_q + rgd_pkg::Q_CW'(push_i.vld0) + rgd_pkg::Q_CW'(push_i.vld1)
            - rgd_pkg::Q_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.vld1) begin
      mem_q[wr_second] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire
